[rtl/core/vxr_pkg.sv]
// Shared types and constants of the vertex XYZ rotation unit.
package vxr_pkg;

  // Fixed-point formats
  localparam int TRIG_WIDTH      = 18;
  localparam int FRAC_BITS       = 16;
  localparam int FRAC_HALF       = 32768;
  localparam int COORD_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam int CFG_IDX_WIDTH = 3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_X = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_X = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_Y = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_Y = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COS_Z = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN_Z = 3'd5;

  // Reset values: zero angle
  localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 18'sh10000;
  localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 18'sh00000;

  // Coefficient pair of one rotation
  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] cos_v;
    logic signed [TRIG_WIDTH-1:0] sin_v;
  } rot_coef_t;

endpackage

[rtl/core/vxr_rot_stage.sv]
// One plane rotation: multiply stage, then round and saturate stage.
module vxr_rot_stage
  import vxr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int PASS_WIDTH  = COORD_WIDTH_DEF + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rot_coef_t                     coef_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  logic        [PASS_WIDTH-1:0]  pass_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] na_o,
  output logic signed [COORD_WIDTH-1:0] nb_o,
  output logic        [PASS_WIDTH-1:0]  pass_o
);

  localparam int PW = COORD_WIDTH + TRIG_WIDTH;
  localparam int SW = PW + 1;
  localparam int QW = SW - FRAC_BITS;
  localparam logic signed [SW-1:0] RndHalf = SW'(FRAC_HALF);
  localparam logic signed [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                 v1_q, v2_q;
  logic                 en1, en2;
  logic signed [PW-1:0] pac_q, pbs_q, pas_q, pbc_q;
  logic signed [PW-1:0] pac_d, pbs_d, pas_d, pbc_d;
  logic [PASS_WIDTH-1:0] pass1_q, pass2_q;
  logic signed [SW-1:0] suma, sumb;
  logic signed [QW-1:0] qa, qb;
  logic signed [COORD_WIDTH-1:0] na_d, nb_d, na_q, nb_q;

  // Stage advances when empty or when the next one takes its word
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Four products of the rotation
  assign pac_d = PW'(a_i) * PW'(coef_i.cos_v);
  assign pbs_d = PW'(b_i) * PW'(coef_i.sin_v);
  assign pas_d = PW'(a_i) * PW'(coef_i.sin_v);
  assign pbc_d = PW'(b_i) * PW'(coef_i.cos_v);

  // Sum, round half up and drop the fraction
  assign suma = SW'(pac_q) + SW'(pbs_q) + RndHalf;
  assign sumb = SW'(pbc_q) - SW'(pas_q) + RndHalf;
  assign qa   = QW'(suma >>> FRAC_BITS);
  assign qb   = QW'(sumb >>> FRAC_BITS);

  // Clamp to the coordinate range
  always_comb begin
    if (qa > QW'(CoordMax)) begin
      na_d = CoordMax;
    end else if (qa < QW'(CoordMin)) begin
      na_d = CoordMin;
    end else begin
      na_d = qa[COORD_WIDTH-1:0];
    end
    if (qb > QW'(CoordMax)) begin
      nb_d = CoordMax;
    end else if (qb < QW'(CoordMin)) begin
      nb_d = CoordMin;
    end else begin
      nb_d = qb[COORD_WIDTH-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      pac_q   <= pac_d;
      pbs_q   <= pbs_d;
      pas_q   <= pas_d;
      pbc_q   <= pbc_d;
      pass1_q <= pass_i;
    end
    if (en2 && v1_q) begin
      na_q    <= na_d;
      nb_q    <= nb_d;
      pass2_q <= pass1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign na_o        = na_q;
  assign nb_o        = nb_q;
  assign pass_o      = pass2_q;

endmodule

[rtl/core/vertex_xyz_rotation_unit.sv]
// Top level of the vertex XYZ rotation unit.
//
// Rotates one vertex per word about X, then Y, then Z. The input stream
// carries px, py, pz in tdata and the last-vertex mark in tlast; the output
// stream carries rx, ry, rz and the same mark. Cosine and sine of each angle
// are written as signed Q1.16 through the cfg port (index 0..5: cos_x, sin_x,
// cos_y, sin_y, cos_z, sin_z); write them only while the unit is empty.
// Each of the three rotations has one multiply stage and one round/saturate
// stage. Throughput is one vertex per cycle while the receiver takes words.
// Each stage holds its word while the next one is full and stalled, so a
// receiver stall backs up stage by stage; empty stages still fill, and no
// word is lost or repeated.
// Reset clears all valid bits and sets every angle to zero (cos 1, sin 0).
module vertex_xyz_rotation_unit
  import vxr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DATA_WIDTH  = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [TRIG_WIDTH-1:0]    cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [DATA_WIDTH-1:0]    s_axis_tdata_i,   // px, py, pz, zero pad
  input  logic                     s_axis_tlast_i,   // final_vertex
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [DATA_WIDTH-1:0]    m_axis_tdata_o,   // rx, ry, rz, zero pad
  output logic                     m_axis_tlast_o    // final_out
);

  localparam int PASS_WIDTH = COORD_WIDTH + 1;

  rot_coef_t coef_x_q, coef_y_q, coef_z_q;

  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic signed [COORD_WIDTH-1:0] z1, y1, x2, z2, rx, ry;
  logic [PASS_WIDTH-1:0] pass_x, pass_y, pass_z;
  logic                  vx, vy, rdy_y, rdy_z;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q <= '{cos_v: COS_RESET, sin_v: SIN_RESET};
      coef_y_q <= '{cos_v: COS_RESET, sin_v: SIN_RESET};
      coef_z_q <= '{cos_v: COS_RESET, sin_v: SIN_RESET};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COS_X: coef_x_q.cos_v <= cfg_wdata_i;
        REG_SIN_X: coef_x_q.sin_v <= cfg_wdata_i;
        REG_COS_Y: coef_y_q.cos_v <= cfg_wdata_i;
        REG_SIN_Y: coef_y_q.sin_v <= cfg_wdata_i;
        REG_COS_Z: coef_z_q.cos_v <= cfg_wdata_i;
        REG_SIN_Z: coef_z_q.sin_v <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the input word
  assign px = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign py = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign pz = s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH];

  // About X: z' from (z, y), y' from (z, y); x rides along
  vxr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .PASS_WIDTH(PASS_WIDTH)) u_rot_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_x_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .a_i         (pz),
    .b_i         (py),
    .pass_i      ({s_axis_tlast_i, px}),
    .out_valid_o (vx),
    .out_ready_i (rdy_y),
    .na_o        (z1),
    .nb_o        (y1),
    .pass_o      (pass_x)
  );

  // About Y: x' from (x, z), z' from (x, z); y rides along
  vxr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .PASS_WIDTH(PASS_WIDTH)) u_rot_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_y_q),
    .in_valid_i  (vx),
    .in_ready_o  (rdy_y),
    .a_i         (pass_x[COORD_WIDTH-1:0]),
    .b_i         (z1),
    .pass_i      ({pass_x[COORD_WIDTH], y1}),
    .out_valid_o (vy),
    .out_ready_i (rdy_z),
    .na_o        (x2),
    .nb_o        (z2),
    .pass_o      (pass_y)
  );

  // About Z: x' from (x, y), y' from (x, y); z rides along
  vxr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .PASS_WIDTH(PASS_WIDTH)) u_rot_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_z_q),
    .in_valid_i  (vy),
    .in_ready_o  (rdy_z),
    .a_i         (x2),
    .b_i         (pass_y[COORD_WIDTH-1:0]),
    .pass_i      ({pass_y[COORD_WIDTH], z2}),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .na_o        (rx),
    .nb_o        (ry),
    .pass_o      (pass_z)
  );

  // Pack the output word
  assign m_axis_tdata_o = DATA_WIDTH'({pass_z[COORD_WIDTH-1:0], ry, rx});
  assign m_axis_tlast_o = pass_z[COORD_WIDTH];

endmodule

[verif/tb_vertex_xyz_rotation_unit.sv]
// Testbench for the vertex XYZ rotation unit: streamed vertices checked against a local predictor.
`timescale 1ns / 100ps

module tb_vertex_xyz_rotation_unit;
  import vxr_pkg::*;

  localparam int CW        = COORD_WIDTH_DEF;
  localparam int DW        = ((3 * CW + 7) / 8) * 8;
  localparam int NUM_TRIG  = int'(REG_SIN_Z) + 1;
  localparam int DRAIN_MAX = 4000;
  localparam int ONE_Q16   = 65536;
  localparam int TRIG_HI   = 131071;
  localparam int TRIG_LO   = -131072;

  localparam logic signed [CW-1:0] COORD_MAX_V = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN_V = {1'b1, {(CW-1){1'b0}}};
  localparam longint COORD_HI = longint'(COORD_MAX_V);
  localparam longint COORD_LO = longint'(COORD_MIN_V);

  // Indexes past the register list; writes there are dropped
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = CFG_IDX_WIDTH'(int'(REG_SIN_Z) + 1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = CFG_IDX_WIDTH'(int'(REG_SIN_Z) + 2);

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } vertex_t;

  typedef longint trig_set_t[NUM_TRIG];

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     cfg_we_i        = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i       = '0;
  logic [TRIG_WIDTH-1:0]    cfg_wdata_i     = '0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic [DW-1:0]            s_axis_tdata_i  = '0;  // px, py, pz, zero pad
  logic                     s_axis_tlast_i  = 1'b0; // final_vertex
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic [DW-1:0]            m_axis_tdata_o;         // rx, ry, rz, zero pad
  logic                     m_axis_tlast_o;         // final_out

  // Shadow copy of the angle registers, sign-extended
  longint  trig_sh[NUM_TRIG];
  vertex_t rotated_q[$];
  int      mismatch_cnt     = 0;
  bit      src_idle_en      = 1'b1;
  bit      sink_idle_en     = 1'b1;
  int      sink_stall_left  = 0;

  vertex_xyz_rotation_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3000000;
    $error("run limit reached with %0d words outstanding", rotated_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Predictor helpers
  function automatic longint sext_trig(input logic [TRIG_WIDTH-1:0] v);
    logic signed [TRIG_WIDTH-1:0] sv;
    sv = v;
    return longint'(sv);
  endfunction

  function automatic longint rot_term(input longint a, input longint ca,
                                     input longint b, input longint cb);
    longint s;
    longint q;
    s = a * ca + b * cb + longint'(FRAC_HALF);
    q = s >>> FRAC_BITS;
    if (q > COORD_HI) return COORD_HI;
    if (q < COORD_LO) return COORD_LO;
    return q;
  endfunction

  function automatic vertex_t predict(input vertex_t v);
    vertex_t r;
    longint  x, y, z, nx, ny, nz;
    x = longint'(v.x);
    y = longint'(v.y);
    z = longint'(v.z);
    // about X
    nz = rot_term(z, trig_sh[REG_COS_X], y, trig_sh[REG_SIN_X]);
    ny = rot_term(z, -trig_sh[REG_SIN_X], y, trig_sh[REG_COS_X]);
    y  = ny;
    z  = nz;
    // about Y
    nx = rot_term(x, trig_sh[REG_COS_Y], z, trig_sh[REG_SIN_Y]);
    nz = rot_term(x, -trig_sh[REG_SIN_Y], z, trig_sh[REG_COS_Y]);
    x  = nx;
    z  = nz;
    // about Z
    nx = rot_term(x, trig_sh[REG_COS_Z], y, trig_sh[REG_SIN_Z]);
    ny = rot_term(x, -trig_sh[REG_SIN_Z], y, trig_sh[REG_COS_Z]);
    r.x    = CW'(nx);
    r.y    = CW'(ny);
    r.z    = CW'(z);
    r.last = v.last;
    return r;
  endfunction

  // Stimulus helpers
  function automatic logic signed [CW-1:0] rand_coord(input int extreme_pct);
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < extreme_pct / 2) return COORD_MAX_V;
    if (pick < extreme_pct) return COORD_MIN_V;
    if (pick < 60) return CW'(int'($urandom_range(0, 20 * ONE_Q16)) - 10 * ONE_Q16);
    return CW'($urandom());
  endfunction

  function automatic vertex_t rand_vertex(input int extreme_pct);
    vertex_t v;
    v.x    = rand_coord(extreme_pct);
    v.y    = rand_coord(extreme_pct);
    v.z    = rand_coord(extreme_pct);
    v.last = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  function automatic longint rand_trig(input bit wide);
    if (wide) return longint'(int'($urandom_range(0, TRIG_HI - TRIG_LO)) + TRIG_LO);
    return longint'(int'($urandom_range(0, 2 * ONE_Q16)) - ONE_Q16);
  endfunction

  function automatic trig_set_t rand_trig_set(input bit wide);
    trig_set_t t;
    for (int i = 0; i < NUM_TRIG; i++) begin
      t[i] = rand_trig(wide);
    end
    return t;
  endfunction

  // Write a burst of registers; call only while nothing is in flight
  task automatic write_burst(input logic [CFG_IDX_WIDTH-1:0] idx_l[$],
                             input longint val_l[$]);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < idx_l.size(); i++) begin
      cfg_idx_i   <= idx_l[i];
      cfg_wdata_i <= TRIG_WIDTH'(val_l[i]);
      if (int'(idx_l[i]) < NUM_TRIG) begin
        trig_sh[idx_l[i]] = sext_trig(TRIG_WIDTH'(val_l[i]));
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_trig_set(input trig_set_t t);
    logic [CFG_IDX_WIDTH-1:0] idx_l[$];
    longint                   val_l[$];
    idx_l = '{REG_COS_X, REG_SIN_X, REG_COS_Y, REG_SIN_Y, REG_COS_Z, REG_SIN_Z};
    for (int i = 0; i < NUM_TRIG; i++) begin
      val_l.push_back(t[idx_l[i]]);
    end
    write_burst(idx_l, val_l);
  endtask

  // Send one word; valid stays high after accept until the next call or release
  task automatic send_vertex(input vertex_t v);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 3) == 0) gap = int'($urandom_range(1, 13));
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rotated_q.push_back(predict(v));
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DW'({v.z, v.y, v.x});
    s_axis_tlast_i  <= v.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic src_release();
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Hold the sender until every expected word has come back or the drain limit runs out
  task automatic wait_drain();
    int waited;
    waited = 0;
    while (rotated_q.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    if (rotated_q.size() != 0) begin
      $error("drain timeout: %0d words outstanding", rotated_q.size());
      mismatch_cnt++;
    end
  endtask

  task automatic send_random(input int n, input int extreme_pct);
    for (int i = 0; i < n; i++) begin
      send_vertex(rand_vertex(extreme_pct));
    end
    src_release();
    wait_drain();
  endtask

  // Compare one output word with the head of the queue
  task automatic check_word();
    vertex_t              exp_v;
    logic signed [CW-1:0] act_x, act_y, act_z;
    if (rotated_q.size() == 0) begin
      $error("unexpected output word");
      mismatch_cnt++;
      return;
    end
    exp_v = rotated_q.pop_front();
    act_x = m_axis_tdata_o[CW-1:0];
    act_y = m_axis_tdata_o[2*CW-1:CW];
    act_z = m_axis_tdata_o[3*CW-1:2*CW];
    if (act_x !== exp_v.x) begin
      $error("rx mismatch: expected %0d, actual %0d", exp_v.x, act_x);
      mismatch_cnt++;
    end
    if (act_y !== exp_v.y) begin
      $error("ry mismatch: expected %0d, actual %0d", exp_v.y, act_y);
      mismatch_cnt++;
    end
    if (act_z !== exp_v.z) begin
      $error("rz mismatch: expected %0d, actual %0d", exp_v.z, act_z);
      mismatch_cnt++;
    end
    if (m_axis_tlast_o !== exp_v.last) begin
      $error("final_out mismatch: expected %0d, actual %0d", exp_v.last, m_axis_tlast_o);
      mismatch_cnt++;
    end
  endtask

  // Sink: check accepted words, drive ready with random stall bursts
  initial begin : sink_proc
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_word();
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        sink_stall_left = int'($urandom_range(1, 13)) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Reset angles: identity on corner coordinates
  task automatic test_reset_defaults();
    logic signed [CW-1:0] corner[5];
    vertex_t              v;
    corner = '{COORD_MAX_V, COORD_MIN_V, CW'(0), CW'(ONE_Q16), CW'(-ONE_Q16)};
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        for (int k = 0; k < 5; k++) begin
          v.x    = corner[i];
          v.y    = corner[j];
          v.z    = corner[k];
          v.last = (k == 4);
          send_vertex(v);
        end
      end
    end
    src_release();
    wait_drain();
  endtask

  // Quarter turn about one axis at a time
  task automatic test_single_axis();
    trig_set_t t;
    for (int ax = 0; ax < 3; ax++) begin
      t = '{ONE_Q16, 0, ONE_Q16, 0, ONE_Q16, 0};
      t[2 * ax]     = 0;
      t[2 * ax + 1] = ONE_Q16;
      write_trig_set(t);
      send_random(60, 10);
    end
  endtask

  // Random angles in the usual range
  task automatic test_random_angles();
    for (int s = 0; s < 6; s++) begin
      write_trig_set(rand_trig_set(1'b0));
      send_random(80, 10);
    end
  endtask

  // Large coefficients and extreme coordinates drive the clamp
  task automatic test_saturation();
    trig_set_t t;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: t = '{ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16};
        1: t = '{-ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16};
        2: t = '{TRIG_HI, TRIG_HI, TRIG_HI, TRIG_HI, TRIG_HI, TRIG_HI};
        3: t = '{TRIG_LO, TRIG_HI, TRIG_LO, TRIG_LO, TRIG_HI, TRIG_LO};
        default: t = rand_trig_set(1'b1);
      endcase
      write_trig_set(t);
      send_random(40, 60);
    end
  endtask

  // Writes past the register list leave the angles unchanged
  task automatic test_unused_index();
    logic [CFG_IDX_WIDTH-1:0] idx_l[$];
    longint                   val_l[$];
    trig_set_t                t;
    t     = rand_trig_set(1'b0);
    idx_l = '{REG_COS_X, REG_SIN_X, REG_COS_Y, REG_SIN_Y, REG_COS_Z, REG_SIN_Z,
              REG_SPARE_A, REG_SPARE_B};
    for (int i = 0; i < NUM_TRIG; i++) begin
      val_l.push_back(t[idx_l[i]]);
    end
    val_l.push_back(rand_trig(1'b1));
    val_l.push_back(rand_trig(1'b1));
    write_burst(idx_l, val_l);
    send_random(40, 10);
  endtask

  // No idling on either side: one word per cycle
  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_trig_set(rand_trig_set(1'b0));
    send_random(280, 10);
  endtask

  // Test sequence
  initial begin : main_proc
    trig_sh = '{ONE_Q16, 0, ONE_Q16, 0, ONE_Q16, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_single_axis();
    test_random_angles();
    test_saturation();
    test_unused_index();
    test_back_to_back();

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && rotated_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[vertex_xyz_rotation_unit.f]
rtl/core/vxr_pkg.sv
rtl/core/vxr_rot_stage.sv
rtl/core/vertex_xyz_rotation_unit.sv
verif/tb_vertex_xyz_rotation_unit.sv
